/* rtl/ild_pkg.sv */
// Shared types, constants and decode tables for the x86 instruction length decoder.
// Used by ild_step and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ild_pkg;

   // entry kind flags
   localparam logic [6:0] K_MODRM = 7'h01;
   localparam logic [6:0] K_PLUSR = 7'h02;
   localparam logic [6:0] K_REG   = 7'h04;
   localparam logic [6:0] K_I8    = 7'h08;
   localparam logic [6:0] K_I16   = 7'h10;
   localparam logic [6:0] K_I32   = 7'h20;
   localparam logic [6:0] K_REL   = 7'h40;

   // decode phases
   localparam logic [2:0] PH_PREFIX   = 3'd0;
   localparam logic [2:0] PH_OPCODE   = 3'd1;
   localparam logic [2:0] PH_MODRM    = 3'd2;
   localparam logic [2:0] PH_SIB      = 3'd3;
   localparam logic [2:0] PH_SIB_MOD0 = 3'd4;
   localparam logic [2:0] PH_SKIP     = 3'd5;

   localparam logic [7:0] PFX_OPSIZE = 8'h66;

   typedef struct packed {
      logic [2:0] phase;
      logic [4:0] byte_count;
      logic [3:0] prefix_position;
      logic [3:0] operand_bytes;
      logic [7:0] held_opcode;
      logic [6:0] entry_flags;
      logic [4:0] skip_remaining;
      logic [4:0] reloc_position;
      logic       reloc_seen;
   } ild_state_type;

   typedef struct packed {
      logic       valid;
      logic [4:0] insn_length;
      logic       opcode_known;
      logic       reloc_present;
      logic [4:0] reloc_offset;
   } ild_result_type;

   typedef struct packed {
      logic       hit;
      logic [6:0] kind;
   } ild_lookup_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] idx;
   } ild_prefix_type;

   localparam ild_state_type ILD_START = '{
      phase:           PH_PREFIX,
      byte_count:      5'd0,
      prefix_position: 4'd0,
      operand_bytes:   4'd4,
      held_opcode:     8'h00,
      entry_flags:     7'h00,
      skip_remaining:  5'd0,
      reloc_position:  5'd0,
      reloc_seen:      1'b0
   };

   // Place of a legacy prefix in the accepted order.
   function automatic ild_prefix_type prefix_lookup(input logic [7:0] b);
      ild_prefix_type r;
      r.hit = 1'b1;
      unique case (b)
         8'hF0:   r.idx = 4'd0;
         8'hF2:   r.idx = 4'd1;
         8'hF3:   r.idx = 4'd2;
         8'h2E:   r.idx = 4'd3;
         8'h36:   r.idx = 4'd4;
         8'h3E:   r.idx = 4'd5;
         8'h26:   r.idx = 4'd6;
         8'h64:   r.idx = 4'd7;
         8'h65:   r.idx = 4'd8;
         8'h66:   r.idx = 4'd9;
         8'h67:   r.idx = 4'd10;
         default: begin
            r.hit = 1'b0;
            r.idx = 4'd0;
         end
      endcase
      return r;
   endfunction

   // First matching opcode entry; group opcodes report K_REG.
   function automatic ild_lookup_type opcode_lookup(input logic [7:0] b);
      ild_lookup_type r;
      r.hit = 1'b1;
      unique case (b) inside
         8'h04, 8'h24, 8'h0C, 8'h2C, 8'h34, 8'hA0, 8'hA2, 8'h6A, 8'hA8:
            r.kind = K_I8;
         8'h05, 8'h25, 8'h0D, 8'h2D, 8'h35, 8'h3D, 8'hA1, 8'hA3, 8'h68, 8'hA9:
            r.kind = K_I32;
         8'h80, 8'h81, 8'h83, 8'hFF, 8'hD9, 8'hDD, 8'hDB, 8'hC6, 8'hC7, 8'h8F,
         8'hF6, 8'hF7:
            r.kind = K_MODRM | K_REG;
         [8'h00:8'h03], [8'h08:8'h0B], [8'h20:8'h23], [8'h28:8'h2B], [8'h30:8'h33],
         8'h39, 8'h8D, [8'h88:8'h8C], 8'h8E, 8'h84, 8'h85:
            r.kind = K_MODRM;
         8'hE8, 8'hE9:
            r.kind = K_I32 | K_REL;
         [8'h48:8'h4F], [8'h50:8'h5F]:
            r.kind = K_PLUSR;
         8'hC8:
            r.kind = K_I16 | K_I8;
         8'hC2:
            r.kind = K_I16;
         8'hCC, 8'hC9, 8'h90, 8'hC3:
            r.kind = 7'h00;
         [8'hB0:8'hB7]:
            r.kind = K_PLUSR | K_I8;
         [8'hB8:8'hBF]:
            r.kind = K_PLUSR | K_I32;
         default: begin
            r.hit  = 1'b0;
            r.kind = 7'h00;
         end
      endcase
      return r;
   endfunction

   // Group opcode entry selected by the ModRM reg field.
   function automatic ild_lookup_type group_lookup(input logic [7:0] op, input logic [2:0] reg_f);
      ild_lookup_type r;
      r.hit  = 1'b0;
      r.kind = 7'h00;
      unique case (op)
         8'h80: begin
            r.hit  = (reg_f == 3'd0) || (reg_f == 3'd1) || (reg_f == 3'd4) ||
                     (reg_f == 3'd5) || (reg_f == 3'd6);
            r.kind = K_MODRM | K_REG | K_I8;
         end
         8'h81: begin
            r.hit  = (reg_f == 3'd0) || (reg_f == 3'd1) || (reg_f == 3'd4) ||
                     (reg_f == 3'd5) || (reg_f == 3'd6);
            r.kind = K_MODRM | K_REG | K_I32;
         end
         8'h83: begin
            r.hit  = (reg_f != 3'd2) && (reg_f != 3'd3);
            r.kind = K_MODRM | K_REG | K_I8;
         end
         8'hFF: begin
            r.hit  = (reg_f == 3'd1) || (reg_f == 3'd2) || (reg_f == 3'd4) ||
                     (reg_f == 3'd6);
            r.kind = K_MODRM | K_REG;
         end
         8'hD9, 8'hDD, 8'h8F: begin
            r.hit  = (reg_f == 3'd0);
            r.kind = K_MODRM | K_REG;
         end
         8'hDB: begin
            r.hit  = (reg_f == 3'd5);
            r.kind = K_MODRM | K_REG;
         end
         8'hC6, 8'hF6: begin
            r.hit  = (reg_f == 3'd0);
            r.kind = K_MODRM | K_REG | K_I8;
         end
         8'hC7, 8'hF7: begin
            r.hit  = (reg_f == 3'd0);
            r.kind = K_MODRM | K_REG | K_I32;
         end
         default: begin
            r.hit  = 1'b0;
            r.kind = 7'h00;
         end
      endcase
      return r;
   endfunction

   function automatic logic [4:0] imm_bytes(input logic [6:0] k, input logic [3:0] opb);
      logic [4:0] n;
      n = 5'd0;
      if ((k & K_I8) != 7'h00)  n = n + 5'd1;
      if ((k & K_I16) != 7'h00) n = n + 5'd2;
      if ((k & K_I32) != 7'h00) n = n + {1'b0, opb};
      return n;
   endfunction

endpackage

`default_nettype wire

/* rtl/ild_step.sv */
// Per-byte decode step: next decoder state and the result for one code byte.
// Depends on ild_pkg for the state/result types and decode tables.
`timescale 1ns / 1ps
`default_nettype none

module ild_step
   import ild_pkg::*;
(
   input  wire logic           long_mode,
   input  wire logic [7:0]     code_byte,
   input  wire ild_state_type  cur,
   output ild_state_type       nxt,
   output ild_result_type      res
);

   ild_prefix_type pfx;
   ild_lookup_type op_lk;
   ild_lookup_type grp_lk;
   ild_state_type  upd;
   logic [4:0]     cnt;
   logic           take_op;
   logic           go_skip;
   logic [4:0]     skip_n;
   logic           do_emit;
   logic           emit_known;
   logic [1:0]     md;
   logic [2:0]     rm;
   logic [6:0]     eff_flags;
   logic [4:0]     disp;
   logic [4:0]     mod_n;

   assign pfx    = prefix_lookup(code_byte);
   assign op_lk  = opcode_lookup(code_byte);
   assign grp_lk = group_lookup(cur.held_opcode, code_byte[5:3]);
   assign md     = code_byte[7:6];
   assign rm     = code_byte[2:0];

   always_comb begin
      upd            = cur;
      cnt            = cur.byte_count + 5'd1;
      upd.byte_count = cnt;
      take_op        = 1'b0;
      go_skip        = 1'b0;
      skip_n         = 5'd0;
      do_emit        = 1'b0;
      emit_known     = 1'b0;
      eff_flags      = cur.entry_flags;
      disp           = 5'd0;
      mod_n          = 5'd0;

      unique case (cur.phase)
         PH_PREFIX: begin
            if (pfx.hit && (pfx.idx >= cur.prefix_position)) begin
               upd.prefix_position = pfx.idx + 4'd1;
               if (code_byte == PFX_OPSIZE) upd.operand_bytes = 4'd2;
            end else if (long_mode && (code_byte[7:4] == 4'h4)) begin
               // REX
               if (code_byte[3]) upd.operand_bytes = 4'd8;
               upd.phase = PH_OPCODE;
            end else begin
               take_op = 1'b1;
            end
         end
         PH_OPCODE: begin
            take_op = 1'b1;
         end
         PH_MODRM: begin
            if ((cur.entry_flags & K_REG) != 7'h00) begin
               eff_flags = grp_lk.kind;
               if (!grp_lk.hit) do_emit = 1'b1;
            end
            if (!do_emit) begin
               upd.entry_flags = eff_flags;
               if (md == 2'd1) disp = 5'd1;
               else if ((md == 2'd2) || ((md == 2'd0) && (rm == 3'd5))) disp = 5'd4;
               // RIP-relative displacement
               if (long_mode && (md == 2'd0) && (rm == 3'd5)) begin
                  upd.reloc_seen     = 1'b1;
                  upd.reloc_position = cnt;
               end
               mod_n = disp + imm_bytes(eff_flags, cur.operand_bytes);
               if ((md != 2'd3) && (rm == 3'd4)) begin
                  upd.skip_remaining = mod_n;
                  upd.phase          = (md == 2'd0) ? PH_SIB_MOD0 : PH_SIB;
               end else begin
                  go_skip = 1'b1;
                  skip_n  = mod_n;
               end
            end
         end
         PH_SIB, PH_SIB_MOD0: begin
            go_skip = 1'b1;
            skip_n  = cur.skip_remaining;
            if ((cur.phase == PH_SIB_MOD0) && (rm == 3'd5)) skip_n = skip_n + 5'd4;
         end
         PH_SKIP: begin
            if (cur.skip_remaining != 5'd0) upd.skip_remaining = cur.skip_remaining - 5'd1;
            if (upd.skip_remaining == 5'd0) begin
               do_emit    = 1'b1;
               emit_known = 1'b1;
            end
         end
         default: begin
            upd = ILD_START;
         end
      endcase

      if (take_op) begin
         if (!op_lk.hit) begin
            do_emit = 1'b1;
         end else if ((op_lk.kind & K_REG) != 7'h00) begin
            upd.held_opcode = code_byte;
            upd.entry_flags = K_MODRM | K_REG;
            upd.phase       = PH_MODRM;
         end else begin
            upd.entry_flags = op_lk.kind;
            if ((op_lk.kind & K_REL) != 7'h00) begin
               upd.reloc_seen     = 1'b1;
               upd.reloc_position = cnt;
            end
            if ((op_lk.kind & K_MODRM) != 7'h00) begin
               upd.phase = PH_MODRM;
            end else begin
               go_skip = 1'b1;
               skip_n  = imm_bytes(op_lk.kind, cur.operand_bytes);
            end
         end
      end

      if (go_skip) begin
         if (skip_n == 5'd0) begin
            do_emit    = 1'b1;
            emit_known = 1'b1;
         end else begin
            upd.skip_remaining = skip_n;
            upd.phase          = PH_SKIP;
         end
      end

      res.valid         = do_emit;
      res.insn_length   = emit_known ? cnt : 5'd0;
      res.opcode_known  = emit_known;
      res.reloc_present = emit_known && upd.reloc_seen;
      res.reloc_offset  = (emit_known && upd.reloc_seen) ? upd.reloc_position : 5'd0;

      nxt = do_emit ? ILD_START : upd;
   end

endmodule

`default_nettype wire

/* rtl/x86_instruction_length_decoder_unit.sv */
// A byte is registered on accept and decoded from the input register; the result register
// takes the instruction's result when the step for its last byte advances.
// Throughput: one code byte per cycle; the only stall is a full result register.
// Reset (synchronous, active high) clears the pipeline valids, the decode state to the
// prefix scan, and long_mode to 0.
// Top level: input register, ild_step decode logic, result register. Uses ild_pkg.
`timescale 1ns / 1ps
`default_nettype none

module x86_instruction_length_decoder_unit
   import ild_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request: [7:0] code_byte
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   // result: [4:0] insn_length, [5] opcode_known, [6] reloc_present,
   //         [11:7] reloc_offset, [15:12] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   ild_state_type  state_ff;
   ild_state_type  state_in;
   ild_result_type step_res;
   logic           long_mode_ff;
   logic           rsp_valid_ff;
   logic [15:0]    rsp_data_ff;
   logic           advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   ild_step u_step (
      .long_mode (long_mode_ff),
      .code_byte (in_byte_ff),
      .cur       (state_ff),
      .nxt       (state_in),
      .res       (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         long_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         long_mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ILD_START;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && step_res.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_res.valid) begin
         rsp_data_ff <= {4'h0, step_res.reloc_offset, step_res.reloc_present,
                         step_res.opcode_known, step_res.insn_length};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // unknown opcode reports all-zero fields
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[5]) |-> (rsp_tdata == 16'h0000))
      else $error("unknown opcode result carries nonzero fields");

   // a known result with a reloc has its reloc offset inside the instruction
   a_known_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[5] && rsp_tdata[6]) |-> (rsp_tdata[11:7] < rsp_tdata[4:0]))
      else $error("reloc offset outside instruction");

   // past the prefix scan at least one byte has been counted
   a_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase != PH_PREFIX) |-> (state_ff.byte_count != 5'd0))
      else $error("decode phase advanced without a byte");

   // operand size is 2, 4 or 8
   a_opsize: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.operand_bytes) && !state_ff.operand_bytes[0])
      else $error("bad operand size");

   // a pending result is never overwritten by the decode step
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking bench for x86_instruction_length_decoder_unit: streams code bytes, predicts
// each instruction result in a scoreboard class and compares what the block returns.
// Depends on ild_pkg (flag constants) and the decoder top level.
`timescale 1ns / 1ps

module testbench
   import ild_pkg::*;
();

   localparam int RUN_LIMIT    = 400000;
   localparam int DRAIN_LIMIT  = 4000;
   localparam int SETTLE       = 6;
   localparam int N_RANDOM     = 6;
   localparam int PHASE_BYTES  = 232;
   localparam int N_OPS        = 74;

   localparam logic [7:0] PREFIX_ORDER [11] = '{
      8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65, 8'h66, 8'h67
   };

   // opcodes with an entry; plus-register forms get random low bits when picked
   localparam logic [7:0] COMMON_OPS [N_OPS] = '{
      8'h04, 8'h05, 8'h80, 8'h81, 8'h83, 8'h00, 8'h01, 8'h02, 8'h03, 8'h24,
      8'h25, 8'h20, 8'h21, 8'h22, 8'h23, 8'hE8, 8'hFF, 8'h39, 8'h3D, 8'h48,
      8'hC8, 8'hD9, 8'hDD, 8'hDB, 8'hCC, 8'hE9, 8'h8D, 8'hC9, 8'h88, 8'h89,
      8'h8A, 8'h8B, 8'h8C, 8'h8E, 8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hB0, 8'hB8,
      8'hC6, 8'hC7, 8'h90, 8'h0C, 8'h0D, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h8F,
      8'h58, 8'h50, 8'h6A, 8'h68, 8'hC3, 8'hC2, 8'h2C, 8'h2D, 8'h28, 8'h29,
      8'h2A, 8'h2B, 8'hA8, 8'hA9, 8'hF6, 8'hF7, 8'h84, 8'h85, 8'h34, 8'h35,
      8'h30, 8'h31, 8'h32, 8'h33
   };

   // unknown group reg, unknown opcode, opsize imm16, repeated prefix, rel32, SIB base 5
   localparam logic [7:0] LEGACY_CASES [21] = '{
      8'hFF, 8'h00, 8'h0F, 8'h66, 8'h05, 8'h34, 8'h12, 8'hF0, 8'hF0,
      8'hE8, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h8B, 8'h04, 8'h25, 8'h11, 8'h22, 8'h33, 8'h44
   };

   // RIP-relative load with REX.W, second REX, prefix after REX
   localparam logic [7:0] LONG_CASES [11] = '{
      8'h48, 8'h8B, 8'h05, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'h40, 8'h40, 8'h48, 8'h66
   };

   typedef enum logic [2:0] {
      SCAN_PREFIX, SCAN_OPCODE, SCAN_MODRM, SCAN_SIB, SCAN_SIB_MOD0, SCAN_TAIL
   } decode_phase_type;

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;

   typedef struct packed {
      logic [4:0] len;
      logic       known;
      logic       rel;
      logic [4:0] roff;
   } insn_result_type;

   class insn_length_scoreboard;
      bit               long_mode;
      decode_phase_type phase;
      logic [4:0]       count;
      logic [3:0]       pfx_next;
      logic [3:0]       opnd_bytes;
      logic [7:0]       held_op;
      logic [6:0]       flags;
      logic [4:0]       tail_left;
      logic [4:0]       reloc_at;
      bit               reloc_hit;
      insn_result_type  expected_q[$];
      int               errors;
      int               n_bytes;
      int               n_insns;
      int               n_unknown;
      int               n_reloc;

      function new();
         long_mode = 1'b0;
         restart();
      endfunction

      function void restart();
         phase      = SCAN_PREFIX;
         count      = 5'd0;
         pfx_next   = 4'd0;
         opnd_bytes = 4'd4;
         held_op    = 8'h00;
         flags      = 7'h00;
         tail_left  = 5'd0;
         reloc_at   = 5'd0;
         reloc_hit  = 1'b0;
      endfunction

      function insn_result_type finish_insn(bit known);
         insn_result_type r;
         r.len   = known ? count : 5'd0;
         r.known = known;
         r.rel   = known && reloc_hit;
         r.roff  = (known && reloc_hit) ? reloc_at : 5'd0;
         restart();
         return r;
      endfunction

      function logic [4:0] imm_len(logic [6:0] k);
         logic [4:0] n;
         n = 5'd0;
         if ((k & K_I8) != 7'h00)  n = n + 5'd1;
         if ((k & K_I16) != 7'h00) n = n + 5'd2;
         if ((k & K_I32) != 7'h00) n = n + {1'b0, opnd_bytes};
         return n;
      endfunction

      // bit r set: ModRM reg value r has an entry for this group opcode
      function logic [7:0] group_mask(logic [7:0] op);
         case (op)
            8'h80, 8'h81:                     return 8'b0111_0011;
            8'h83:                            return 8'b1111_0011;
            8'hFF:                            return 8'b0101_0110;
            8'hDB:                            return 8'b0010_0000;
            8'hD9, 8'hDD, 8'h8F, 8'hC6, 8'hC7,
            8'hF6, 8'hF7:                     return 8'b0000_0001;
            default:                          return 8'b0000_0000;
         endcase
      endfunction

      function logic [6:0] group_imm(logic [7:0] op);
         case (op)
            8'h80, 8'h83, 8'hC6, 8'hF6: return K_I8;
            8'h81, 8'hC7, 8'hF7:        return K_I32;
            default:                    return 7'h00;
         endcase
      endfunction

      function bit base_kind(input logic [7:0] b, output logic [6:0] k);
         k = 7'h00;
         case (b)
            8'h04, 8'h0C, 8'h24, 8'h2C, 8'h34, 8'h6A, 8'hA0, 8'hA2, 8'hA8:
               k = K_I8;
            8'h05, 8'h0D, 8'h25, 8'h2D, 8'h35, 8'h3D, 8'h68, 8'hA1, 8'hA3, 8'hA9:
               k = K_I32;
            8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h09, 8'h0A, 8'h0B,
            8'h20, 8'h21, 8'h22, 8'h23, 8'h28, 8'h29, 8'h2A, 8'h2B,
            8'h30, 8'h31, 8'h32, 8'h33, 8'h39, 8'h84, 8'h85,
            8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E:
               k = K_MODRM;
            8'hE8, 8'hE9:
               k = K_I32 | K_REL;
            8'h80, 8'h81, 8'h83, 8'h8F, 8'hC6, 8'hC7, 8'hD9, 8'hDB, 8'hDD,
            8'hF6, 8'hF7, 8'hFF:
               k = K_MODRM | K_REG;
            8'hC2: k = K_I16;
            8'hC8: k = K_I16 | K_I8;
            8'h90, 8'hC3, 8'hC9, 8'hCC: k = 7'h00;
            default:
               case (b & 8'hF8)
                  8'h48, 8'h50, 8'h58: k = K_PLUSR;
                  8'hB0:               k = K_PLUSR | K_I8;
                  8'hB8:               k = K_PLUSR | K_I32;
                  default:             return 1'b0;
               endcase
         endcase
         return 1'b1;
      endfunction

      function bit tail_or_finish(input logic [4:0] n, output insn_result_type res);
         res = '0;
         if (n == 5'd0) begin
            res = finish_insn(1'b1);
            return 1'b1;
         end
         tail_left = n;
         phase     = SCAN_TAIL;
         return 1'b0;
      endfunction

      function bit take_opcode(input logic [7:0] b, output insn_result_type res);
         logic [6:0] k;
         res = '0;
         if (!base_kind(b, k)) begin
            res = finish_insn(1'b0);
            return 1'b1;
         end
         if ((k & K_REG) != 7'h00) begin
            held_op = b;
            flags   = K_MODRM | K_REG;
            phase   = SCAN_MODRM;
            return 1'b0;
         end
         flags = k;
         if ((k & K_REL) != 7'h00) begin
            reloc_hit = 1'b1;
            reloc_at  = count;
         end
         if ((k & K_MODRM) != 7'h00) begin
            phase = SCAN_MODRM;
            return 1'b0;
         end
         return tail_or_finish(imm_len(k), res);
      endfunction

      // One code byte; returns 1 when it completes an instruction.
      function bit predict(input logic [7:0] b, output insn_result_type res);
         logic [7:0] m;
         logic [4:0] n;
         logic [1:0] md;
         logic [2:0] rm;
         int         j;
         res   = '0;
         count = count + 5'd1;
         md    = b[7:6];
         rm    = b[2:0];
         case (phase)
            SCAN_PREFIX: begin
               for (j = pfx_next; j < 11; j++)
                  if (PREFIX_ORDER[j] == b) begin
                     pfx_next = 4'(j + 1);
                     if (b == PFX_OPSIZE) opnd_bytes = 4'd2;
                     return 1'b0;
                  end
               if (long_mode && b[7:4] == 4'h4) begin
                  if (b[3]) opnd_bytes = 4'd8;
                  phase = SCAN_OPCODE;
                  return 1'b0;
               end
               return take_opcode(b, res);
            end
            SCAN_OPCODE: return take_opcode(b, res);
            SCAN_MODRM: begin
               if ((flags & K_REG) != 7'h00) begin
                  m = group_mask(held_op);
                  if (!m[b[5:3]]) begin
                     res = finish_insn(1'b0);
                     return 1'b1;
                  end
                  flags = K_MODRM | K_REG | group_imm(held_op);
               end
               if (md == 2'd1) n = 5'd1;
               else if (md == 2'd2 || (md == 2'd0 && rm == 3'd5)) n = 5'd4;
               else n = 5'd0;
               if (long_mode && md == 2'd0 && rm == 3'd5) begin
                  reloc_hit = 1'b1;
                  reloc_at  = count;
               end
               n = n + imm_len(flags);
               if (md != 2'd3 && rm == 3'd4) begin
                  tail_left = n;
                  phase     = (md == 2'd0) ? SCAN_SIB_MOD0 : SCAN_SIB;
                  return 1'b0;
               end
               return tail_or_finish(n, res);
            end
            SCAN_SIB, SCAN_SIB_MOD0: begin
               n = tail_left;
               // base 5 without a ModRM displacement carries disp32
               if (phase == SCAN_SIB_MOD0 && rm == 3'd5) n = n + 5'd4;
               return tail_or_finish(n, res);
            end
            SCAN_TAIL: begin
               if (tail_left > 5'd0) tail_left = tail_left - 5'd1;
               if (tail_left == 5'd0) begin
                  res = finish_insn(1'b1);
                  return 1'b1;
               end
               return 1'b0;
            end
            default: begin
               restart();
               return 1'b0;
            end
         endcase
      endfunction

      function void note(logic [7:0] b);
         insn_result_type r;
         n_bytes++;
         if (predict(b, r)) begin
            expected_q.push_back(r);
            if (!r.known) n_unknown++;
            if (r.rel) n_reloc++;
         end
      endfunction

      task report(string msg);
         if (errors < 30) $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check(logic [15:0] d);
         insn_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result %h arrived with nothing outstanding", d));
            return;
         end
         want = expected_q.pop_front();
         n_insns++;
         if (d[4:0] != want.len)
            report($sformatf("insn %0d: length %0d, want %0d", n_insns, d[4:0], want.len));
         if (d[5] != want.known)
            report($sformatf("insn %0d: known %b, want %b", n_insns, d[5], want.known));
         if (d[6] != want.rel)
            report($sformatf("insn %0d: reloc %b, want %b", n_insns, d[6], want.rel));
         if (d[11:7] != want.roff)
            report($sformatf("insn %0d: reloc offset %0d, want %0d", n_insns, d[11:7],
                             want.roff));
         if (d[15:12] != 4'h0)
            report($sformatf("insn %0d: pad bits %h not zero", n_insns, d[15:12]));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   insn_length_scoreboard sb;
   insn_length_scoreboard gen;   // runs ahead of the driver to shape instructions
   logic [7:0]            code_q[$];
   rx_mode_type           rx_mode = RX_ALWAYS;
   logic [4:0]            rx_tick = 5'd0;
   int                    cycles = 0;

   x86_instruction_length_decoder_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),     // [7:0] code_byte
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),     // [4:0] length, [5] known, [6] reloc, [11:7] offset
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      rx_tick <= rx_tick + 5'd1;
      case (rx_mode)
         RX_ALWAYS: rsp_tready <= 1'b1;
         RX_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
         default:   rsp_tready <= (rx_tick[4:3] != 2'b11) && (rx_tick[1:0] != 2'b10);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata);
   end

   function automatic bit feed_byte(logic [7:0] b);
      insn_result_type r;
      code_q.push_back(b);
      return gen.predict(b, r);
   endfunction

   task automatic build_insn();
      logic [7:0] op;
      logic [7:0] b;
      logic [7:0] m;
      bit         got;
      int         guard;
      int         t;
      for (int j = 0; j < 11; j++)
         if ($urandom_range(0, 11) == 0) void'(feed_byte(PREFIX_ORDER[j]));
      if (gen.long_mode && $urandom_range(0, 2) == 0) void'(feed_byte({4'h4, 4'($urandom)}));
      op = COMMON_OPS[$urandom_range(0, N_OPS - 1)];
      if (op == 8'h48 || op == 8'h50 || op == 8'h58 || op == 8'hB0 || op == 8'hB8)
         op[2:0] = 3'($urandom);
      got   = feed_byte(op);
      guard = 0;
      while (!got && guard < 24) begin
         b = 8'($urandom);
         if (gen.phase == SCAN_MODRM) begin
            case ($urandom_range(0, 3))
               0:       b[2:0] = 3'd4;
               1:       b[2:0] = 3'd5;
               default: ;
            endcase
            // mostly steer the reg field onto an existing group entry
            if ((gen.flags & K_REG) != 7'h00) begin
               m = gen.group_mask(gen.held_op);
               t = 0;
               while (t < 8 && !m[b[5:3]]) begin
                  b[5:3] = 3'($urandom);
                  t++;
               end
            end
         end else if (gen.phase == SCAN_SIB_MOD0 && $urandom_range(0, 1) == 0) begin
            b[2:0] = 3'd5;
         end
         got = feed_byte(b);
         guard++;
      end
   endtask

   task automatic build_noise();
      case ($urandom_range(0, 2))
         0: repeat ($urandom_range(1, 3)) void'(feed_byte(8'($urandom)));
         1: begin
            void'(feed_byte(8'h67));
            void'(feed_byte(PREFIX_ORDER[$urandom_range(0, 10)]));
         end
         default: begin
            void'(feed_byte({4'h4, 4'($urandom)}));
            void'(feed_byte(PREFIX_ORDER[$urandom_range(0, 10)]));
         end
      endcase
   endtask

   task automatic send_code(bit bursty);
      int left;
      int gap;
      left = 0;
      foreach (code_q[i]) begin
         if (bursty && left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            left = $urandom_range(1, 20);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= code_q[i];
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         left--;
      end
      req_tvalid <= 1'b0;
      code_q.delete();
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      @(posedge clock);
      while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (sb.expected_q.size() != 0) begin
         sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
         sb.expected_q.delete();
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_long_mode(bit v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.long_mode  = v;
      gen.long_mode = v;
   endtask

   initial begin
      sb  = new();
      gen = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_long_mode(1'b0);
      foreach (LEGACY_CASES[i]) void'(feed_byte(LEGACY_CASES[i]));
      send_code(1'b0);
      drain();

      set_long_mode(1'b1);
      foreach (LONG_CASES[i]) void'(feed_byte(LONG_CASES[i]));
      send_code(1'b1);
      drain();

      for (int ph = 0; ph < N_RANDOM; ph++) begin
         set_long_mode(ph % 2 == 0);
         rx_mode = rx_mode_type'(ph % 3);
         while (code_q.size() < PHASE_BYTES) begin
            if ($urandom_range(0, 99) < 85) build_insn();
            else build_noise();
         end
         send_code(ph != 0);
         drain();
      end

      $display("Sent %0d code bytes, checked %0d results (%0d unknown, %0d relocatable)",
               sb.n_bytes, sb.n_insns, sb.n_unknown, sb.n_reloc);
      $display("Long mode switched over %0d phases under sender gaps and receiver stalls",
               N_RANDOM + 2);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
rtl/ild_pkg.sv
rtl/ild_step.sv
rtl/x86_instruction_length_decoder_unit.sv
test/testbench.sv
